@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside of reset.
`define GSA_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define GSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/gsa_pkg.sv @@
// ---------------------------------------------------------------------------
// gsa_pkg
// Types and constants shared by the generational slot allocator modules.
// ---------------------------------------------------------------------------
package gsa_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam int SLOT_W    = 10;
	localparam int GEN_W     = 32;
	localparam int ELEM_W    = 11;
	localparam int CMP_W     = 17;
	localparam int QDEPTH    = 2;
	localparam int QPW       = $clog2(QDEPTH);
	localparam int QCW       = $clog2(QDEPTH + 1);

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_STALE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_FREE,
		OP_LOOKUP,
		OP_RANGE,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SLOT_W-1:0] slot_index;
		logic [GEN_W-1:0]  key_generation;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] out_slot;
		logic [GEN_W-1:0]  out_generation;
		logic [ELEM_W-1:0] element_index;
	} rsp_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  key_gen;
	} qent_t;

	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qhead_t;

endpackage

@@ rtl/generational_slot_allocator.sv @@
// ---------------------------------------------------------------------------
// generational_slot_allocator
// Fixed-capacity slot table handing out keys of slot and generation, with
// allocate, free and lookup commands and an implicit free list.
// ---------------------------------------------------------------------------
// In the execution unit each command first reads the slot's link and
// generation entries from the tables, then checks them, updates the free
// list head and writes the entry back. A two-entry queue sits in front, so
// start may be raised again while a command executes; busy is high only while
// that queue is full, and the unit takes the next queued command only once the
// last one is through. Every command yields exactly one result, shown for one
// cycle with done high; the result cannot be held off, so it
// must be captured in that cycle. No clearing pass is needed after reset:
// slots not yet reached by allocation read as freshly reset.

module generational_slot_allocator #(
	parameter int SLOTS = gsa_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  gsa_pkg::req_t request,
	output logic          busy,
	output logic          done,
	output gsa_pkg::rsp_t result
);
	import gsa_pkg::*;

	qhead_t head;
	logic   pop;

	gsa_front #(
		.SLOTS(SLOTS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.head   (head),
		.pop    (pop)
	);

	gsa_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

@@ rtl/gsa_front.sv @@
// ---------------------------------------------------------------------------
// gsa_front
// Accepts items, classifies them by kind and range, and queues them for the
// execution side.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gsa_front #(
	parameter int SLOTS = gsa_pkg::SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  gsa_pkg::req_t  request,
	output logic           busy,
	output gsa_pkg::qhead_t head,
	input  logic           pop
);
	import gsa_pkg::*;

	qent_t            q_mem_q [QDEPTH];
	logic [QPW-1:0]   wptr_q;
	logic [QPW-1:0]   rptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             push;
	logic             do_pop;
	qent_t            ent_d;

	assign busy   = (cnt_q == QCW'(QDEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (cnt_q != '0);

	always_comb begin
		ent_d.slot    = request.slot_index;
		ent_d.key_gen = request.key_generation;
		case (request.kind)
			KIND_ALLOC: begin
				ent_d.op = OP_ALLOC;
			end
			KIND_FREE, KIND_LOOKUP: begin
				if ({{(CMP_W-SLOT_W){1'b0}}, request.slot_index} >= CMP_W'(SLOTS)) begin
					ent_d.op = OP_RANGE;
				end else if (request.kind == KIND_FREE) begin
					ent_d.op = OP_FREE;
				end else begin
					ent_d.op = OP_LOOKUP;
				end
			end
			default: begin
				ent_d.op = OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wptr_q] <= ent_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPW'(QDEPTH - 1)) ? '0 : wptr_q + QPW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QPW'(QDEPTH - 1)) ? '0 : rptr_q + QPW'(1);
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.ent   = q_mem_q[rptr_q];

	`GSA_ASSERT_ALWAYS(a_q_bound, clk, arst_n, cnt_q <= QCW'(QDEPTH), "queue count overflow")

endmodule

@@ rtl/gsa_back.sv @@
// ---------------------------------------------------------------------------
// gsa_back
// Executes queued items against the link and generation tables and the free
// list head, and presents one registered result per item.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gsa_back #(
	parameter int SLOTS = gsa_pkg::SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gsa_pkg::qhead_t head,
	output logic            pop,
	output logic            done,
	output gsa_pkg::rsp_t   result
);
	import gsa_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t           state_q;
	qent_t            cur_q;
	logic [LW-1:0]    addr_q;
	logic [LW-1:0]    rd_link_q;
	logic [GEN_W-1:0] rd_gen_q;
	logic [LW-1:0]    free_head_q;
	logic [LW-1:0]    live_q;
	logic [LW-1:0]    wm_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic [LW-1:0]    link_mem [SLOTS];
	logic [GEN_W-1:0] gen_mem  [SLOTS];

	logic [LW-1:0]    raddr;
	logic             untouched;
	logic [LW-1:0]    eff_link;
	logic [GEN_W-1:0] eff_gen;
	logic             full;
	logic             key_ok;
	logic             we;
	logic [LW-1:0]    wlink;
	logic [GEN_W-1:0] wgen;
	logic [LW-1:0]    free_head_d;
	logic [LW-1:0]    live_d;
	logic [LW-1:0]    wm_d;
	rsp_t             rsp_d;

	assign pop   = (state_q == ST_IDLE) && head.valid;
	assign raddr = (head.ent.op == OP_ALLOC) ? free_head_q : LW'(head.ent.slot);

	// Slots at or above the watermark have never been written and are read as
	// holding reset contents: a link to the next slot and a generation of zero.
	assign untouched = (addr_q >= wm_q);
	assign eff_link  = untouched ? addr_q + LW'(1) : rd_link_q;
	assign eff_gen   = untouched ? '0 : rd_gen_q;
	assign full      = (live_q >= LW'(SLOTS)) || (free_head_q >= LW'(SLOTS));
	assign key_ok    = (eff_link == addr_q) && (eff_gen == cur_q.key_gen);

	always_comb begin
		we          = 1'b0;
		wlink       = eff_link;
		wgen        = eff_gen;
		free_head_d = free_head_q;
		live_d      = live_q;
		wm_d        = wm_q;
		rsp_d.status         = ST_OK;
		rsp_d.out_slot       = cur_q.slot;
		rsp_d.out_generation = '0;
		rsp_d.element_index  = '0;
		case (cur_q.op)
			OP_ALLOC: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					we                   = 1'b1;
					wlink                = addr_q;
					free_head_d          = eff_link;
					live_d               = live_q + LW'(1);
					rsp_d.out_slot       = SLOT_W'(addr_q);
					rsp_d.out_generation = eff_gen;
					if (untouched) begin
						wm_d = wm_q + LW'(1);
					end
				end
			end
			OP_FREE: begin
				if (!key_ok) begin
					rsp_d.status = ST_STALE;
				end else begin
					we          = 1'b1;
					wlink       = free_head_q;
					wgen        = eff_gen + GEN_W'(1);
					free_head_d = addr_q;
					if (live_q != '0) begin
						live_d = live_q - LW'(1);
					end
				end
			end
			OP_LOOKUP: begin
				if (!key_ok) begin
					rsp_d.status = ST_STALE;
				end else begin
					rsp_d.element_index = ELEM_W'(eff_link);
				end
			end
			OP_RANGE: begin
				rsp_d.status = ST_RANGE;
			end
			default: begin
				rsp_d.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_link_q <= link_mem[AW'(raddr)];
			rd_gen_q  <= gen_mem[AW'(raddr)];
			cur_q     <= head.ent;
			addr_q    <= raddr;
		end
		if ((state_q == ST_EXEC) && we) begin
			link_mem[AW'(addr_q)] <= wlink;
			gen_mem[AW'(addr_q)]  <= wgen;
		end
		if (state_q == ST_EXEC) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_head_q <= '0;
			live_q      <= '0;
			wm_q        <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					free_head_q <= free_head_d;
					live_q      <= live_d;
					wm_q        <= wm_d;
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

	`GSA_ASSERT_IMPL(a_done_src, clk, arst_n, done_q, $past(state_q == ST_EXEC), "result without execute")
	`GSA_ASSERT_ALWAYS(a_full_agree, clk, arst_n, (free_head_q == LW'(SLOTS)) == (live_q == LW'(SLOTS)), "free list end and live count disagree")
	`GSA_ASSERT_ALWAYS(a_wm_bound, clk, arst_n, (wm_q <= LW'(SLOTS)) && (live_q <= wm_q), "watermark out of bounds")

endmodule
